/* rtl/core/tsb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsb_pkg
// word types, op codes, blit modes and register indexes of the tile blitter
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_PUT   = 3'd1;
    localparam logic [2:0] OP_BLIT  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_MIR_H  = 2'd1;
    localparam logic [1:0] MODE_MIR_V  = 2'd2;
    localparam logic [1:0] MODE_TRANSP = 2'd3;

    localparam logic [2:0] CFG_SRC_W = 3'd0;
    localparam logic [2:0] CFG_SRC_H = 3'd1;
    localparam logic [2:0] CFG_TGT_W = 3'd2;
    localparam logic [2:0] CFG_TGT_H = 3'd3;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 7;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [7:0] coord_x;
        logic signed [7:0] coord_y;
        logic [7:0]        tile_value;
        logic [1:0]        blit_mode;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_tile;
        logic       in_bounds;
    } t_out_word;

endpackage
`default_nettype wire

/* rtl/core/tile_sprite_blitter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tile_sprite_blitter
// sprite store and tile buffer with load, put, read, clear and clipped blit
// ----------------------------------------------------------------------------
// input words arrive on i_in_valid / o_in_stall, one result word per input
// word leaves on o_out_valid / i_out_stall; both sides move a word at an edge
// with valid high and stall low. the user writes the size registers on the
// cfg port only while the block is idle; the block does not enforce this.
// one item at a time; a single shared coordinate unit (x and y add or
// subtract, then bound compare) serves load, put, read and blit. steps
// from accept to result valid, after the exec state:
//   load, put, blit with empty sprite, other codes: straight to response
//   read: registered buffer read if in bounds, else straight to response
//   blit: every source tile in row order, one source tile per cycle, then
//         a drain state before the response
//   clear: every buffer entry to zero, one buffer entry per cycle
// the next word can be taken once its predecessor's result shows, while
// that result may still wait in the output register.
// after reset the whole buffer is swept to zero with o_in_stall high; cfg
// writes are taken during the sweep. a stalled result holds in the output
// register and the block waits there before taking the next one into it.
// ----------------------------------------------------------------------------
module tile_sprite_blitter
    import tsb_pkg::*;
#(
    parameter int SOURCE_DIM_MAX = 32,
    parameter int TARGET_DIM_MAX = 64,
    parameter int TILE_BITS      = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire t_in_word                 i_in_word,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output t_out_word                     o_out_word
);

    localparam int SCW   = (SOURCE_DIM_MAX > 1) ? $clog2(SOURCE_DIM_MAX) : 1;
    localparam int TCW   = (TARGET_DIM_MAX > 1) ? $clog2(TARGET_DIM_MAX) : 1;
    localparam int SDEP  = SOURCE_DIM_MAX * SOURCE_DIM_MAX;
    localparam int TDEP  = TARGET_DIM_MAX * TARGET_DIM_MAX;
    localparam int SAW   = (SDEP > 1) ? $clog2(SDEP) : 1;
    localparam int TAW   = (TDEP > 1) ? $clog2(TDEP) : 1;
    localparam logic [7:0] SMAX8 = 8'(SOURCE_DIM_MAX);
    localparam logic [7:0] TMAX8 = 8'(TARGET_DIM_MAX);
    localparam logic [TAW-1:0] CLR_LAST = TAW'(TDEP - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_BLIT  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_RWAIT = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [5:0] r_src_w, r_src_h;
    logic [6:0] r_tgt_w, r_tgt_h;

    logic [2:0] r_state, n_state;
    logic       r_boot;
    logic [TAW-1:0] r_clr_addr;

    logic [2:0]          r_op;
    logic signed [7:0]   r_x, r_y;
    logic [TILE_BITS-1:0] r_val;
    logic [1:0]          r_mode;

    logic [SCW-1:0] r_ix, r_iy, r_pix, r_piy;
    logic           r_p_valid;

    logic [TILE_BITS-1:0] r_src_mem [SDEP];
    logic [TILE_BITS-1:0] r_tgt_mem [TDEP];
    logic [TILE_BITS-1:0] r_src_q, r_tgt_q;

    t_out_word r_res;
    t_out_word r_out_word;
    logic      r_out_valid;

    logic [7:0] src_wc, src_hc, tgt_wc, tgt_hc, lim_w, lim_h;
    logic [9:0] base_x, base_y, off_x, off_y, cx, cy;
    logic       unit_ok;
    logic       src_lim;
    logic [SAW-1:0] src_waddr, src_raddr;
    logic [TAW-1:0] tgt_addr, tgt_waddr;
    logic           tgt_we;
    logic [TILE_BITS-1:0] tgt_wdata;
    logic           row_end, last_tile, sprite_empty, out_free;

    // size register values are clamped at the parameter maximum when used
    assign src_wc = ({2'b0, r_src_w} > SMAX8) ? SMAX8 : {2'b0, r_src_w};
    assign src_hc = ({2'b0, r_src_h} > SMAX8) ? SMAX8 : {2'b0, r_src_h};
    assign tgt_wc = ({1'b0, r_tgt_w} > TMAX8) ? TMAX8 : {1'b0, r_tgt_w};
    assign tgt_hc = ({1'b0, r_tgt_h} > TMAX8) ? TMAX8 : {1'b0, r_tgt_h};

    // shared coordinate unit: base +/- offset, then bound check
    assign src_lim = (r_state == S_EXEC) && (r_op == OP_LOAD);
    assign lim_w   = src_lim ? src_wc : tgt_wc;
    assign lim_h   = src_lim ? src_hc : tgt_hc;
    assign base_x  = {{2{r_x[7]}}, r_x};
    assign base_y  = {{2{r_y[7]}}, r_y};
    assign off_x   = r_p_valid ? {2'b0, 8'(r_pix)} : 10'd0;
    assign off_y   = r_p_valid ? {2'b0, 8'(r_piy)} : 10'd0;
    assign cx      = (r_mode == MODE_MIR_H) ? base_x - off_x : base_x + off_x;
    assign cy      = (r_mode == MODE_MIR_V) ? base_y - off_y : base_y + off_y;
    assign unit_ok = !cx[9] && !cy[9] && (cx[8:0] < {1'b0, lim_w})
                     && (cy[8:0] < {1'b0, lim_h});

    assign src_waddr = SAW'(cy[SCW-1:0] * SOURCE_DIM_MAX + cx[SCW-1:0]);
    assign src_raddr = SAW'(r_iy * SOURCE_DIM_MAX + r_ix);
    assign tgt_addr  = TAW'(cy[TCW-1:0] * TARGET_DIM_MAX + cx[TCW-1:0]);

    assign row_end      = (8'(r_ix) == src_wc - 8'd1);
    assign last_tile    = row_end && (8'(r_iy) == src_hc - 8'd1);
    assign sprite_empty = (src_wc == 8'd0) || (src_hc == 8'd0);
    assign out_free     = !r_out_valid || !i_out_stall;

    // buffer write port
    always_comb begin
        tgt_we    = 1'b0;
        tgt_waddr = tgt_addr;
        tgt_wdata = r_val;
        if (r_state == S_CLR) begin
            tgt_we    = 1'b1;
            tgt_waddr = r_clr_addr;
            tgt_wdata = '0;
        end else if (r_p_valid) begin
            tgt_we    = unit_ok && !((r_mode == MODE_TRANSP) && (r_src_q == '0));
            tgt_wdata = r_src_q;
        end else if ((r_state == S_EXEC) && (r_op == OP_PUT)) begin
            tgt_we = unit_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[tgt_waddr] <= tgt_wdata;
        end
        r_tgt_q <= r_tgt_mem[tgt_addr];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && (r_op == OP_LOAD) && unit_ok) begin
            r_src_mem[src_waddr] <= r_val;
        end
        r_src_q <= r_src_mem[src_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_BLIT:  n_state = sprite_empty ? S_RESP : S_BLIT;
                    OP_READ:  n_state = unit_ok ? S_RWAIT : S_RESP;
                    OP_CLEAR: n_state = S_CLR;
                    default:  n_state = S_RESP;
                endcase
            end
            S_BLIT: begin
                if (last_tile) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_RESP;
            S_RWAIT: n_state = S_RESP;
            S_CLR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = r_boot ? S_IDLE : S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_boot      <= 1'b1;
            r_clr_addr  <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_src_w     <= 6'd32;
            r_src_h     <= 6'd32;
            r_tgt_w     <= 7'd64;
            r_tgt_h     <= 7'd64;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == S_BLIT);
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SRC_W: r_src_w <= i_cfg_wdata[5:0];
                    CFG_SRC_H: r_src_h <= i_cfg_wdata[5:0];
                    CFG_TGT_W: r_tgt_w <= i_cfg_wdata;
                    CFG_TGT_H: r_tgt_h <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + TAW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_boot <= 1'b0;
                end
            end else begin
                r_clr_addr <= '0;
            end
            if ((r_state == S_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item, walk counters and result
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op   <= i_in_word.op;
            r_x    <= i_in_word.coord_x;
            r_y    <= i_in_word.coord_y;
            r_val  <= TILE_BITS'(i_in_word.tile_value);
            r_mode <= i_in_word.blit_mode;
        end
        if (r_state == S_EXEC) begin
            r_ix            <= '0;
            r_iy            <= '0;
            r_res.read_tile <= 8'd0;
            r_res.in_bounds <= unit_ok && (r_op <= OP_READ);
        end
        if (r_state == S_BLIT) begin
            r_pix <= r_ix;
            r_piy <= r_iy;
            if (row_end) begin
                r_ix <= '0;
                r_iy <= r_iy + SCW'(1);
            end else begin
                r_ix <= r_ix + SCW'(1);
            end
        end
        if (r_state == S_RWAIT) begin
            r_res.read_tile <= 8'(r_tgt_q);
        end
        if ((r_state == S_RESP) && out_free) begin
            r_out_word <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

/* rtl/core/tsb_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsb_checker
// port-level checks of the tile blitter, bound to the top level
// ----------------------------------------------------------------------------
module tsb_checker
    import tsb_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // held result word keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // a nonzero tile only comes from an in-bounds read
    a_tile_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.read_tile != 8'd0) |-> o_out_word.in_bounds)
        else $error("nonzero tile without in_bounds");

    // one word at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");

    // buffer sweep follows reset
    a_sweep_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> o_in_stall)
        else $error("input open during buffer sweep");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind tile_sprite_blitter tsb_checker u_tsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire
